### rtl/iee_pkg.sv
package iee_pkg;

    localparam int OPERATOR_DEPTH_DEF = 16;
    localparam int VALUE_DEPTH_DEF    = 16;
    localparam int VALUE_WIDTH_DEF    = 32;

    localparam logic [2:0] OP_OPEN = 3'd0;
    localparam logic [2:0] OP_ADD  = 3'd1;
    localparam logic [2:0] OP_SUB  = 3'd2;
    localparam logic [2:0] OP_MUL  = 3'd3;
    localparam logic [2:0] OP_DIV  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DIVZERO   = 3'd1;
    localparam logic [2:0] ST_MALFORMED = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_BADCHAR   = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_OPEN  = 8'd40;
    localparam logic [7:0] CH_CLOSE = 8'd41;
    localparam logic [7:0] CH_MUL   = 8'd42;
    localparam logic [7:0] CH_ADD   = 8'd43;
    localparam logic [7:0] CH_SUB   = 8'd45;
    localparam logic [7:0] CH_DIV   = 8'd47;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_OPWAIT,
        S_OPREAD,
        S_VWAIT1,
        S_VREAD1,
        S_VWAIT2,
        S_VREAD2,
        S_ALU,
        S_DIVWAIT,
        S_PUSHOP,
        S_DRAIN,
        S_RWAIT,
        S_RREAD,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CTX_CLOSE,
        CTX_OPER,
        CTX_DRAIN
    } ctx_t;

    typedef struct packed {
        logic start;
        logic neg_q;
    } div_ctl_t;

    function automatic logic [1:0] op_rank(input logic [2:0] op);
        logic [1:0] r;
        r = 2'd0;
        if (op == OP_MUL || op == OP_DIV)
            r = 2'd2;
        else if (op == OP_ADD || op == OP_SUB)
            r = 2'd1;
        return r;
    endfunction

endpackage

### rtl/iee_divider.sv
module iee_divider #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  iee_pkg::div_ctl_t      ctl,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   busy,
    output logic [VALUE_WIDTH-1:0] quotient
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH:0]   r_reg, r_next;
    logic [VALUE_WIDTH:0]   trial;

    always_comb
    begin
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        q_next   = q_reg;
        d_next   = d_reg;
        r_next   = r_reg;
        trial    = {r_reg[VALUE_WIDTH-1:0], q_reg[VALUE_WIDTH-1]} - {1'b0, d_reg};
        if (ctl.start)
        begin
            cnt_next = CW'(VALUE_WIDTH);
            neg_next = ctl.neg_q;
            q_next   = dividend;
            d_next   = divisor;
            r_next   = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[VALUE_WIDTH])
            begin
                r_next = trial;
                q_next = {q_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[VALUE_WIDTH-1:0], q_reg[VALUE_WIDTH-1]};
                q_next = {q_reg[VALUE_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
    end

    assign busy     = (cnt_reg != '0) || ctl.start;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

### rtl/iee_stack_mem.sv
module iee_stack_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### rtl/infix_expression_evaluator.sv
// Shunting-yard evaluator: one ASCII character per request, single digit operands,
// + - * / with the usual precedence and parentheses, 32-bit wrapping arithmetic with
// division truncating toward zero. A result (value, status) is given only for the
// request marked is_last, after which the block is clear for the next expression;
// status 0 ok, 1 divide by zero, 2 malformed, 3 stack overflow, 4 bad character, and
// value is 0 whenever status is not 0. Operator and value stacks sit in single-port-
// read memories with a registered read port, and one request is worked at a time, so
// ready_in stays low until it is done. A digit, '(' or bad character is handled in the
// dispatch state; an operator or ')' then reads the operator stack top and pops or
// pushes, each operator applied reads two values and runs the ALU, and each division
// also waits on the bit-serial divider; the request marked is_last drains the operator
// stack and sets the result, and no request is taken while a result waits.
module infix_expression_evaluator #(
    parameter int OPERATOR_DEPTH = iee_pkg::OPERATOR_DEPTH_DEF,
    parameter int VALUE_DEPTH    = iee_pkg::VALUE_DEPTH_DEF,
    parameter int VALUE_WIDTH    = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    output logic               ready_in,
    input  logic [7:0]         char_code,
    input  logic               is_last,
    output logic               valid_out,
    input  logic               ready_out,
    output logic signed [31:0] value,
    output logic [2:0]         status
);

    localparam int OA = $clog2(OPERATOR_DEPTH);
    localparam int VA = $clog2(VALUE_DEPTH);
    localparam int OC = $clog2(OPERATOR_DEPTH + 1);
    localparam int VC = $clog2(VALUE_DEPTH + 1);

    iee_pkg::state_t state_reg, state_next;
    iee_pkg::ctx_t   ctx_reg, ctx_next;

    logic [OC-1:0]          ocnt_reg, ocnt_next;
    logic [VC-1:0]          vcnt_reg, vcnt_next;
    logic [2:0]             err_reg, err_next;
    logic [7:0]             ch_reg, ch_next;
    logic                   last_reg, last_next;
    logic [2:0]             op_reg, op_next;
    logic [2:0]             top_reg, top_next;
    logic [VALUE_WIDTH-1:0] b_reg, b_next;
    logic [VALUE_WIDTH-1:0] a_reg, a_next;
    logic                   ov_reg, ov_next;
    logic signed [31:0]     value_reg, value_next;
    logic [2:0]             status_reg, status_next;

    logic                   o_we, v_we;
    logic [OA-1:0]          o_waddr, o_raddr;
    logic [2:0]             o_wdata, o_rdata;
    logic [VA-1:0]          v_waddr, v_raddr;
    logic [VALUE_WIDTH-1:0] v_wdata, v_rdata;

    iee_pkg::div_ctl_t      dctl;
    logic                   dbusy;
    logic [VALUE_WIDTH-1:0] dq;
    logic [VALUE_WIDTH-1:0] abs_a, abs_b;
    logic [VALUE_WIDTH-1:0] alu_r;

    iee_stack_mem #(.DEPTH(OPERATOR_DEPTH), .WIDTH(3)) u_ops (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata)
    );

    iee_stack_mem #(.DEPTH(VALUE_DEPTH), .WIDTH(VALUE_WIDTH)) u_vals (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );

    iee_divider #(.VALUE_WIDTH(VALUE_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .ctl(dctl), .dividend(abs_a), .divisor(abs_b),
        .busy(dbusy), .quotient(dq)
    );

    assign abs_a = a_reg[VALUE_WIDTH-1] ? (~a_reg + 1'b1) : a_reg;
    assign abs_b = b_reg[VALUE_WIDTH-1] ? (~b_reg + 1'b1) : b_reg;

    always_comb
    begin
        case (op_reg)
            iee_pkg::OP_ADD: alu_r = a_reg + b_reg;
            iee_pkg::OP_SUB: alu_r = a_reg - b_reg;
            iee_pkg::OP_MUL: alu_r = a_reg * b_reg;
            default:         alu_r = dq;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        ctx_next    = ctx_reg;
        ocnt_next   = ocnt_reg;
        vcnt_next   = vcnt_reg;
        err_next    = err_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        op_next     = op_reg;
        top_next    = top_reg;
        b_next      = b_reg;
        a_next      = a_reg;
        ov_next     = ov_reg;
        value_next  = value_reg;
        status_next = status_reg;
        o_we        = 1'b0;
        o_waddr     = OA'(ocnt_reg);
        o_wdata     = op_reg;
        o_raddr     = OA'(ocnt_reg - 1'b1);
        v_we        = 1'b0;
        v_waddr     = VA'(vcnt_reg);
        v_wdata     = alu_r;
        v_raddr     = VA'(vcnt_reg - 1'b1);
        dctl.start  = 1'b0;
        dctl.neg_q  = a_reg[VALUE_WIDTH-1] ^ b_reg[VALUE_WIDTH-1];
        ready_in    = 1'b0;

        case (state_reg)
            iee_pkg::S_IDLE:
            begin
                ready_in = !ov_reg;
                if (valid_in && !ov_reg)
                begin
                    ch_next    = char_code;
                    last_next  = is_last;
                    state_next = iee_pkg::S_DISPATCH;
                end
            end
            iee_pkg::S_DISPATCH:
            begin
                state_next = last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE;
                ctx_next   = iee_pkg::CTX_DRAIN;
                if (err_reg == iee_pkg::ST_OK)
                begin
                    if (ch_reg >= iee_pkg::CH_ZERO && ch_reg <= iee_pkg::CH_NINE)
                    begin
                        if (vcnt_reg >= VC'(VALUE_DEPTH))
                            err_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            v_we      = 1'b1;
                            v_wdata   = VALUE_WIDTH'(ch_reg - iee_pkg::CH_ZERO);
                            vcnt_next = vcnt_reg + 1'b1;
                        end
                    end
                    else if (ch_reg == iee_pkg::CH_OPEN)
                    begin
                        if (ocnt_reg >= OC'(OPERATOR_DEPTH))
                            err_next = iee_pkg::ST_OVERFLOW;
                        else
                        begin
                            o_we      = 1'b1;
                            o_wdata   = iee_pkg::OP_OPEN;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                    end
                    else if (ch_reg == iee_pkg::CH_CLOSE)
                    begin
                        ctx_next   = iee_pkg::CTX_CLOSE;
                        state_next = iee_pkg::S_OPWAIT;
                    end
                    else if (ch_reg == iee_pkg::CH_ADD || ch_reg == iee_pkg::CH_SUB ||
                             ch_reg == iee_pkg::CH_MUL || ch_reg == iee_pkg::CH_DIV)
                    begin
                        ctx_next   = iee_pkg::CTX_OPER;
                        state_next = iee_pkg::S_OPWAIT;
                        if (ch_reg == iee_pkg::CH_ADD)
                            op_next = iee_pkg::OP_ADD;
                        else if (ch_reg == iee_pkg::CH_SUB)
                            op_next = iee_pkg::OP_SUB;
                        else if (ch_reg == iee_pkg::CH_MUL)
                            op_next = iee_pkg::OP_MUL;
                        else
                            op_next = iee_pkg::OP_DIV;
                    end
                    else
                        err_next = iee_pkg::ST_BADCHAR;
                end
            end
            // top of operator stack, read issued from ocnt-1
            iee_pkg::S_OPWAIT:
            begin
                if (err_reg != iee_pkg::ST_OK)
                    state_next = (ctx_reg == iee_pkg::CTX_DRAIN) ? iee_pkg::S_RWAIT :
                                 (last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE);
                else if (ocnt_reg == '0)
                begin
                    if (ctx_reg == iee_pkg::CTX_CLOSE)
                    begin
                        err_next   = iee_pkg::ST_MALFORMED;
                        state_next = last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE;
                    end
                    else if (ctx_reg == iee_pkg::CTX_OPER)
                        state_next = iee_pkg::S_PUSHOP;
                    else
                        state_next = iee_pkg::S_RWAIT;
                end
                else
                    state_next = iee_pkg::S_OPREAD;
            end
            iee_pkg::S_OPREAD:
            begin
                top_next = o_rdata;
                case (ctx_reg)
                    iee_pkg::CTX_CLOSE:
                    begin
                        ocnt_next = ocnt_reg - 1'b1;
                        if (o_rdata == iee_pkg::OP_OPEN)
                            state_next = last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE;
                        else
                            state_next = iee_pkg::S_VWAIT1;
                    end
                    iee_pkg::CTX_OPER:
                    begin
                        if (iee_pkg::op_rank(o_rdata) >= iee_pkg::op_rank(op_reg))
                        begin
                            ocnt_next  = ocnt_reg - 1'b1;
                            state_next = iee_pkg::S_VWAIT1;
                        end
                        else
                            state_next = iee_pkg::S_PUSHOP;
                    end
                    default:
                    begin
                        ocnt_next = ocnt_reg - 1'b1;
                        if (o_rdata == iee_pkg::OP_OPEN)
                        begin
                            err_next   = iee_pkg::ST_MALFORMED;
                            state_next = iee_pkg::S_RWAIT;
                        end
                        else
                            state_next = iee_pkg::S_VWAIT1;
                    end
                endcase
            end
            iee_pkg::S_VWAIT1:
            begin
                if (vcnt_reg < VC'(2))
                begin
                    err_next   = iee_pkg::ST_MALFORMED;
                    state_next = (ctx_reg == iee_pkg::CTX_DRAIN) ? iee_pkg::S_RWAIT :
                                 (last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE);
                end
                else
                    state_next = iee_pkg::S_VREAD1;
            end
            iee_pkg::S_VREAD1:
            begin
                b_next     = v_rdata;
                v_raddr    = VA'(vcnt_reg - 2'd2);
                state_next = iee_pkg::S_VWAIT2;
            end
            iee_pkg::S_VWAIT2:
            begin
                v_raddr    = VA'(vcnt_reg - 2'd2);
                state_next = iee_pkg::S_VREAD2;
            end
            iee_pkg::S_VREAD2:
            begin
                a_next     = v_rdata;
                vcnt_next  = vcnt_reg - 2'd2;
                op_next    = top_reg;
                top_next   = op_reg;
                state_next = iee_pkg::S_ALU;
            end
            iee_pkg::S_ALU:
            begin
                if (op_reg == iee_pkg::OP_DIV)
                begin
                    if (b_reg == '0)
                    begin
                        err_next   = iee_pkg::ST_DIVZERO;
                        op_next    = top_reg;
                        state_next = (ctx_reg == iee_pkg::CTX_DRAIN) ? iee_pkg::S_RWAIT :
                                     (last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE);
                    end
                    else
                    begin
                        dctl.start = 1'b1;
                        state_next = iee_pkg::S_DIVWAIT;
                    end
                end
                else
                    state_next = iee_pkg::S_DIVWAIT;
            end
            iee_pkg::S_DIVWAIT:
            begin
                if (!dbusy)
                begin
                    v_we       = 1'b1;
                    vcnt_next  = vcnt_reg + 1'b1;
                    op_next    = top_reg;
                    state_next = iee_pkg::S_OPWAIT;
                end
            end
            iee_pkg::S_PUSHOP:
            begin
                if (ocnt_reg >= OC'(OPERATOR_DEPTH))
                    err_next = iee_pkg::ST_OVERFLOW;
                else
                begin
                    o_we      = 1'b1;
                    ocnt_next = ocnt_reg + 1'b1;
                end
                state_next = last_reg ? iee_pkg::S_DRAIN : iee_pkg::S_IDLE;
            end
            iee_pkg::S_DRAIN:
            begin
                ctx_next   = iee_pkg::CTX_DRAIN;
                state_next = iee_pkg::S_OPWAIT;
            end
            iee_pkg::S_RWAIT:
            begin
                v_raddr = '0;
                if (err_reg == iee_pkg::ST_OK && vcnt_reg != VC'(1))
                    err_next = iee_pkg::ST_MALFORMED;
                state_next = iee_pkg::S_RREAD;
            end
            iee_pkg::S_RREAD:
            begin
                value_next  = (err_reg == iee_pkg::ST_OK) ?
                              32'(signed'(v_rdata)) : 32'sd0;
                status_next = err_reg;
                ov_next     = 1'b1;
                ocnt_next   = '0;
                vcnt_next   = '0;
                err_next    = iee_pkg::ST_OK;
                state_next  = iee_pkg::S_IDLE;
            end
            default:
                state_next = iee_pkg::S_IDLE;
        endcase

        if (ov_reg && ready_out)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iee_pkg::S_IDLE;
            ctx_reg   <= iee_pkg::CTX_DRAIN;
            ocnt_reg  <= '0;
            vcnt_reg  <= '0;
            err_reg   <= iee_pkg::ST_OK;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            ocnt_reg  <= ocnt_next;
            vcnt_reg  <= vcnt_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        last_reg   <= last_next;
        op_reg     <= op_next;
        top_reg    <= top_next;
        b_reg      <= b_next;
        a_reg      <= a_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign valid_out = ov_reg;
    assign value     = value_reg;
    assign status    = status_reg;

endmodule
